// ----- rtl/core/bba_pkg.sv -----
// bba_pkg: shared types and constants of the bitmap block allocator
// no dependencies
package bba_pkg;

	localparam int unsigned MAX_BLOCKS_DEF    = 1024;
	localparam int unsigned MAP_WORD_BITS_DEF = 16;

	localparam int unsigned BYTES_W = 16;
	localparam int unsigned POOL_W  = 11;

	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;
	localparam logic [POOL_W-1:0]  POOL_BLOCKS_RST = 11'd1024;

	localparam logic       REG_BLOCK_BYTES = 1'b0;
	localparam logic       REG_POOL_BLOCKS = 1'b1;

	localparam logic       MODE_ALLOC = 1'b0;
	localparam logic       MODE_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_NO_HEAD = 2'd2;

	typedef struct packed {
		logic                mode;
		logic [BYTES_W-1:0]  request_bytes;
		logic [BYTES_W-1:0]  release_offset;
	} bba_in_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [BYTES_W-1:0]  block_offset;
	} bba_out_t;

	typedef struct packed {
		logic                start;
		logic [BYTES_W-1:0]  dividend;
		logic [BYTES_W-1:0]  divisor;
	} bba_div_req_t;

	typedef struct packed {
		logic                done;
		logic [BYTES_W-1:0]  quotient;
		logic [BYTES_W-1:0]  remainder;
	} bba_div_rsp_t;

endpackage

// ----- rtl/core/bitmap_block_allocator_top.sv -----
// bitmap_block_allocator_top: bitmap first-fit block allocator
// Channels: in_valid/in_stall carry one allocate or free transaction
// (bba_in_t); out_valid/out_stall return one result (bba_out_t) for each.
// cfg_valid/cfg_ready write block_bytes (index 0) and pool_blocks (index 1);
// writes are taken at any time but belong to idle periods.
//
// Each transaction runs alone. A serial divider first turns the byte
// request or offset into blocks, then the used and head maps, held in one
// memory of MAX_BLOCKS/MAP_WORD_BITS words (rounded up), are walked block
// by block through a registered read. An allocate scans for a free run (up
// to the pool length), reading the map word anew for each block, then marks
// the run back word by word; a free clears the freed blocks word by word.
//
// Reset clears the configuration to 64 bytes and 1024 blocks and then runs
// a clearing pass over every memory word, during which no transaction is
// accepted. A result waits in its output register while out_stall is high;
// the next transaction is taken once it has left.
module bitmap_block_allocator_top
	import bba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS    = MAX_BLOCKS_DEF,
	parameter int unsigned MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bba_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bba_out_t           out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [BYTES_W-1:0] cfg_data
);

	localparam int unsigned WORDS  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BW     = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
	localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned CAP_W  = (IDX_W > POOL_W) ? IDX_W : POOL_W;
	localparam int unsigned PROD_W = 2 * BYTES_W + 1;

	typedef struct packed {
		logic [MAP_WORD_BITS-1:0] used;
		logic [MAP_WORD_BITS-1:0] head;
	} map_word_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_ARD, S_ASCAN, S_AMUL, S_AMARK, S_AMWR,
		S_FRD, S_FCHK, S_FWR, S_FNEXT, S_OUT
	} state_t;

	map_word_t mem [WORDS];
	map_word_t rd_q;
	map_word_t wr_word;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          rd_en, wr_en;

	state_t             state_q;
	logic [BYTES_W-1:0] bb_q;
	logic [POOL_W-1:0]  pool_q;
	bba_in_t            item_q;
	bba_out_t           res_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   need_q;
	logic [IDX_W-1:0]   start_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AW-1:0]      clr_q;
	map_word_t          wbuf_q;
	logic               first_q;

	bba_div_req_t div_req;
	bba_div_rsp_t div_rsp;
	logic [BYTES_W-1:0] bb_eff;
	logic [CAP_W-1:0]   pool_eff;
	logic [CAP_W-1:0]   idx_ext;
	logic [BW-1:0]      bit_sel;
	logic [AW-1:0]      word_sel;
	logic [BYTES_W:0]   need_calc;

	bba_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign bb_eff   = (bb_q == '0) ? BYTES_W'(1) : bb_q;
	assign pool_eff = (CAP_W'(pool_q) > CAP_W'(MAX_BLOCKS)) ? CAP_W'(MAX_BLOCKS)
	                                                          : CAP_W'(pool_q);
	assign idx_ext  = CAP_W'(idx_q);
	assign bit_sel  = BW'(idx_q % MAP_WORD_BITS);
	assign word_sel = AW'(idx_q / MAP_WORD_BITS);

	assign need_calc = (BYTES_W+1)'(div_rsp.quotient)
	                 + ((div_rsp.remainder != '0) ? (BYTES_W+1)'(1) : '0);

	assign div_req.start    = (state_q == S_IDLE) && in_valid;
	assign div_req.dividend = (in_data.mode == MODE_ALLOC) ? in_data.request_bytes
	                                                         : in_data.release_offset;
	assign div_req.divisor  = bb_eff;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = word_sel;
		wr_en   = 1'b0;
		wr_addr = word_sel;
		wr_word = wbuf_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_word = '0;
			end
			S_ARD, S_FRD: rd_en = 1'b1;
			S_AMWR: begin
				wr_en = 1'b1;
				wr_word.used[bit_sel] = 1'b1;
				if (first_q)
					wr_word.head[bit_sel] = 1'b1;
			end
			S_FWR: begin
				wr_en = 1'b1;
				wr_word.used[bit_sel] = 1'b0;
				if (first_q)
					wr_word.head[bit_sel] = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_word;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			bb_q    <= BLOCK_BYTES_RST;
			pool_q  <= POOL_BLOCKS_RST;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_BLOCK_BYTES)
					bb_q <= cfg_data;
				else
					pool_q <= cfg_data[POOL_W-1:0];
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_q <= '0;
						if (item_q.mode == MODE_ALLOC) begin
							need_q  <= need_calc[IDX_W-1:0];
							idx_q   <= '0;
							cnt_q   <= '0;
							if (need_calc == '0
							    || need_calc > (BYTES_W+1)'(pool_eff)) begin
								res_q.status <= ST_NO_ROOM;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_ARD;
							end
						end else begin
							idx_q   <= IDX_W'(div_rsp.quotient);
							first_q <= 1'b1;
							if (div_rsp.quotient >= BYTES_W'(pool_eff)) begin
								res_q.status <= ST_NO_HEAD;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_FRD;
							end
						end
					end
				end
				S_ARD: state_q <= S_ASCAN;
				S_ASCAN: begin
					if (rd_q.used[bit_sel]) begin
						cnt_q <= '0;
					end else if (cnt_q + 1'b1 == need_q) begin
						start_q <= idx_q + 1'b1 - need_q;
						state_q <= S_AMUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!(!rd_q.used[bit_sel] && cnt_q + 1'b1 == need_q)) begin
						if (idx_ext + 1'b1 >= pool_eff) begin
							res_q.status <= ST_NO_ROOM;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_ARD;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_AMUL: begin
					prod_q <= PROD_W'(start_q) * PROD_W'(bb_eff);
					idx_q  <= start_q;
					cnt_q  <= '0;
					state_q <= S_AMARK;
				end
				S_AMARK: begin
					if (prod_q > PROD_W'(16'hFFFF)) begin
						res_q.status <= ST_NO_ROOM;
						state_q      <= S_OUT;
					end else begin
						res_q.block_offset <= prod_q[BYTES_W-1:0];
						state_q            <= S_FRD;
						first_q            <= 1'b1;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					wbuf_q <= rd_q;
					if (item_q.mode == MODE_ALLOC) begin
						state_q <= S_AMWR;
					end else if (first_q) begin
						if (!rd_q.head[bit_sel]) begin
							res_q.status <= ST_NO_HEAD;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_FWR;
						end
					end else if (rd_q.used[bit_sel] && !rd_q.head[bit_sel]) begin
						state_q <= S_FWR;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_AMWR: begin
					wbuf_q  <= wr_word;
					first_q <= 1'b0;
					cnt_q   <= cnt_q + 1'b1;
					idx_q   <= idx_q + 1'b1;
					if (cnt_q + 1'b1 == need_q)
						state_q <= S_OUT;
					else if (bit_sel == BW'(MAP_WORD_BITS - 1))
						state_q <= S_FRD;
				end
				S_FWR: begin
					wbuf_q  <= wr_word;
					first_q <= 1'b0;
					idx_q   <= idx_q + 1'b1;
					if (first_q && !wbuf_q.used[bit_sel]) begin
						state_q <= S_OUT;
					end else if (idx_ext + 1'b1 >= pool_eff) begin
						state_q <= S_OUT;
					end else if (bit_sel == BW'(MAP_WORD_BITS - 1)) begin
						state_q <= S_FRD;
					end else begin
						state_q <= S_FNEXT;
					end
				end
				S_FNEXT: begin
					if (wbuf_q.used[bit_sel] && !wbuf_q.head[bit_sel])
						state_q <= S_FWR;
					else
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bba_divider.sv -----
// bba_divider: 16-bit restoring divider, one quotient bit per cycle
// depends on bba_pkg
module bba_divider
	import bba_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  bba_div_req_t req,
	output bba_div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(BYTES_W + 1);

	logic [BYTES_W-1:0] quo_q;
	logic [BYTES_W-1:0] rem_q;
	logic [BYTES_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BYTES_W:0]   trial;
	logic [BYTES_W:0]   shifted;

	assign shifted = {rem_q, quo_q[BYTES_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BYTES_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[BYTES_W]) begin
				rem_q <= trial[BYTES_W-1:0];
				quo_q <= {quo_q[BYTES_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[BYTES_W-1:0];
				quo_q <= {quo_q[BYTES_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/core/bba_checker.sv -----
// bba_checker: port-level assertions for the bitmap block allocator
// depends on bba_pkg and bitmap_block_allocator_top
module bba_checker
	import bba_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input bba_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("transaction accepted while result pending");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status == ST_OK || out_data.status == ST_NO_ROOM
		           || out_data.status == ST_NO_HEAD)
		else $error("bad status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.block_offset == '0)
		else $error("failed result carries an offset");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
